FILE: design/joystick_report_framer_and_idle_gate_macros.svh
// Assertion macros used by the checker file.
`ifndef JOYSTICK_REPORT_FRAMER_AND_IDLE_GATE_MACROS_SVH
`define JOYSTICK_REPORT_FRAMER_AND_IDLE_GATE_MACROS_SVH

// Same-cycle implication, gated by reset.
`define JRF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("joystick framer check failed");

// Next-cycle implication, gated by reset.
`define JRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("joystick framer check failed");

`endif

FILE: design/jrf_pkg.sv
`default_nettype none

package jrf_pkg;

    localparam int NUM_INTERFACES = 4;
    localparam int NUM_AXES       = 4;
    localparam int REPORT_LEN     = NUM_AXES + 1;
    localparam int STORE_LEN      = REPORT_LEN * NUM_INTERFACES;
    localparam int IFX_W          = (NUM_INTERFACES > 1) ? $clog2(NUM_INTERFACES) : 1;
    localparam int ADDR_W         = $clog2(STORE_LEN);
    localparam int K_W            = $clog2(REPORT_LEN);

    localparam logic [7:0]  SYNC_MARK  = 8'hFF;
    localparam logic [15:0] RESET_IDLE = 16'h03E8;

    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_CTRL = 2'd1;
    localparam logic [1:0] KIND_IDLE = 2'd2;

    typedef enum logic [2:0] {
        OP_SERIAL   = 3'd0,
        OP_TICK     = 3'd1,
        OP_POLL     = 3'd2,
        OP_SET_IDLE = 3'd3,
        OP_GET_IDLE = 3'd4,
        OP_GET_RPT  = 3'd5
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic ld_item;
        logic serial;
        logic ser2;
        logic tick;
        logic set_idle;
        logic clr_k;
        logic cmp_step;
        logic emit_rpt;
        logic emit_idle;
        logic clr_cnt;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic ifx_ok;
        logic poll_ok;
        logic need_ser2;
        logic expired;
        logic diff_any;
        logic k_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: design/jrf_dpath.sv
`default_nettype none

module jrf_dpath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire jrf_pkg::cmd_t      cmd,
    output jrf_pkg::sts_t           sts,
    input  wire logic [2:0]         opcode,
    input  wire logic [7:0]         data_byte,
    input  wire logic [15:0]        interface_index,
    input  wire logic               endpoint_ready,
    input  wire logic               device_configured,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              result_kind,
    output logic [2:0]              result_interface,
    output logic [7:0]              result_byte,
    output logic                    last_of_run
);

    localparam int NI = jrf_pkg::NUM_INTERFACES;
    localparam int SL = jrf_pkg::STORE_LEN;
    localparam int AW = jrf_pkg::ADDR_W;
    localparam int IW = jrf_pkg::IFX_W;
    localparam int KW = jrf_pkg::K_W;

    // latched item
    jrf_pkg::op_t    op_reg;
    logic [7:0]      db_reg;
    logic [IW-1:0]   ifx_reg;
    logic            ifx_ok_reg;
    logic            rdy_reg;
    logic            conf_reg;

    logic [7:0]      rpt_reg  [SL];
    logic [7:0]      sent_reg [SL];
    logic [AW-1:0]   wp_reg, wp_next;
    logic [1:0]      sync_reg, sync_next;
    logic [15:0]     cnt_reg [NI];
    logic [15:0]     per_reg [NI];
    logic [15:0]     limit_reg;
    logic [KW-1:0]   k_reg;
    logic            diff_reg;

    logic            ov_reg;
    logic [1:0]      kind_reg;
    logic [IW-1:0]   oifx_reg;
    logic [7:0]      obyte_reg;
    logic            olast_reg;

    logic            in_ok;
    logic [IW-1:0]   in_ifx;
    logic [AW-1:0]   wp_inc;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;
    logic [AW-1:0]   rd_addr;
    logic            byte_diff;
    logic            load_out;

    assign in_ok  = interface_index < 16'(NI);
    assign in_ifx = in_ok ? interface_index[IW-1:0] : '0;
    assign wp_inc = (wp_reg == AW'(SL - 1)) ? '0 : wp_reg + AW'(1);

    assign rd_addr   = AW'(ifx_reg) * AW'(jrf_pkg::REPORT_LEN) + AW'(k_reg);
    assign byte_diff = rpt_reg[rd_addr] != sent_reg[rd_addr];

    // serial write path
    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = wp_reg;
        wr_data   = db_reg;
        wp_next   = wp_reg;
        sync_next = sync_reg;
        if (cmd.serial)
        begin
            if (db_reg == jrf_pkg::SYNC_MARK)
            begin
                if (sync_reg != 2'd2)
                    sync_next = sync_reg + 2'd1;
            end
            else
            begin
                sync_next = 2'd0;
                wr_en     = 1'b1;
                if (sync_reg == 2'd2)
                begin
                    wr_addr = '0;
                    wp_next = AW'(1);
                end
                else
                begin
                    if (sync_reg == 2'd1)
                        wr_data = jrf_pkg::SYNC_MARK;
                    wp_next = wp_inc;
                end
            end
        end
        else if (cmd.ser2)
        begin
            wr_en   = 1'b1;
            wp_next = wp_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            op_reg     <= jrf_pkg::op_t'(opcode);
            db_reg     <= data_byte;
            ifx_reg    <= in_ifx;
            ifx_ok_reg <= in_ok;
            rdy_reg    <= endpoint_ready;
            conf_reg   <= device_configured;
        end
        if (load_out)
        begin
            oifx_reg  <= ifx_reg;
            if (cmd.emit_idle)
            begin
                kind_reg  <= jrf_pkg::KIND_IDLE;
                obyte_reg <= per_reg[ifx_reg][9:2];
                olast_reg <= 1'b1;
            end
            else
            begin
                kind_reg  <= (op_reg == jrf_pkg::OP_POLL) ? jrf_pkg::KIND_INT
                                                           : jrf_pkg::KIND_CTRL;
                obyte_reg <= rpt_reg[rd_addr];
                olast_reg <= sts.k_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SL; i++)
            begin
                rpt_reg[i]  <= 8'd0;
                sent_reg[i] <= 8'd0;
            end
            for (int i = 0; i < NI; i++)
            begin
                cnt_reg[i] <= 16'd0;
                per_reg[i] <= jrf_pkg::RESET_IDLE;
            end
            wp_reg    <= '0;
            sync_reg  <= 2'd0;
            limit_reg <= jrf_pkg::RESET_IDLE;
            k_reg     <= '0;
            diff_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            wp_reg   <= wp_next;
            sync_reg <= sync_next;
            if (wr_en)
                rpt_reg[wr_addr] <= wr_data;
            // poll sends: copy the report byte as it goes out
            if (cmd.emit_rpt && op_reg == jrf_pkg::OP_POLL)
                sent_reg[rd_addr] <= rpt_reg[rd_addr];
            if (cfg_we)
                limit_reg <= cfg_wdata;
            for (int i = 0; i < NI; i++)
            begin
                if (cmd.tick)
                    cnt_reg[i] <= cnt_reg[i] + 16'd1;
                else if (cmd.clr_cnt && ifx_reg == IW'(i))
                    cnt_reg[i] <= 16'd0;
            end
            if (cmd.set_idle)
                per_reg[ifx_reg] <= 16'({db_reg, 2'b00});
            if (cmd.clr_k)
                k_reg <= '0;
            else if (cmd.cmp_step || cmd.emit_rpt)
                k_reg <= k_reg + KW'(1);
            if (cmd.clr_k)
                diff_reg <= 1'b0;
            else if (cmd.cmp_step)
                diff_reg <= diff_reg | byte_diff;
            if (load_out)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    assign load_out = cmd.emit_rpt | cmd.emit_idle;

    always_comb
    begin
        sts.op        = op_reg;
        sts.ifx_ok    = ifx_ok_reg;
        sts.poll_ok   = ifx_ok_reg & rdy_reg & conf_reg;
        sts.need_ser2 = (db_reg != jrf_pkg::SYNC_MARK) && (sync_reg == 2'd1);
        sts.expired   = ((per_reg[ifx_reg] != 16'd0) && (cnt_reg[ifx_reg] >= per_reg[ifx_reg]))
                        || (cnt_reg[ifx_reg] >= limit_reg);
        sts.diff_any  = diff_reg | byte_diff;
        sts.k_last    = k_reg == KW'(jrf_pkg::REPORT_LEN - 1);
        sts.out_free  = !ov_reg || out_ready;
    end

    assign out_valid        = ov_reg;
    assign result_kind      = kind_reg;
    assign result_interface = 3'(oifx_reg);
    assign result_byte      = obyte_reg;
    assign last_of_run      = olast_reg;

endmodule

`default_nettype wire

FILE: design/jrf_ctrl.sv
`default_nettype none

module jrf_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire jrf_pkg::sts_t  sts,
    output jrf_pkg::cmd_t       cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DECODE  = 6'b000010,
        S_SER2    = 6'b000100,
        S_CMP     = 6'b001000,
        S_EMIT    = 6'b010000,
        S_IDLEOUT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ld_item = in_valid;
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                cmd.clr_k  = 1'b1;
                state_next = S_IDLE;
                unique case (sts.op)
                    jrf_pkg::OP_SERIAL:
                    begin
                        cmd.serial = 1'b1;
                        if (sts.need_ser2)
                            state_next = S_SER2;
                    end
                    jrf_pkg::OP_TICK:     cmd.tick = 1'b1;
                    jrf_pkg::OP_POLL:
                    begin
                        if (sts.poll_ok)
                            state_next = S_CMP;
                    end
                    jrf_pkg::OP_SET_IDLE: cmd.set_idle = sts.ifx_ok;
                    jrf_pkg::OP_GET_IDLE:
                    begin
                        if (sts.ifx_ok)
                            state_next = S_IDLEOUT;
                    end
                    jrf_pkg::OP_GET_RPT:  state_next = S_EMIT;
                    default:              state_next = S_IDLE;
                endcase
            end
            S_SER2:
            begin
                cmd.ser2   = 1'b1;
                state_next = S_IDLE;
            end
            S_CMP:
            begin
                cmd.cmp_step = 1'b1;
                if (sts.k_last)
                begin
                    if (sts.diff_any || sts.expired)
                    begin
                        cmd.clr_k   = 1'b1;
                        cmd.clr_cnt = 1'b1;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_rpt = 1'b1;
                    if (sts.k_last)
                        state_next = S_IDLE;
                end
            end
            S_IDLEOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_idle = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: design/joystick_report_framer_and_idle_gate.sv
// A get report or get idle transfer is latched and decoded before its first result byte is
//   registered; a poll that sends first walks a compare over the report; output stalls add delay.
// The report walks go one byte per cycle, the emit walk only while the output is free; a
//   serial byte after a lone sync mark takes an extra write state. One item at a time.
// Reset (rst_n, async low) clears both report stores, counters, sync count and write
//   position; idle periods and the default limit return to 1000.
`default_nettype none

module joystick_report_framer_and_idle_gate (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  opcode,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] interface_index,
    input  wire logic        endpoint_ready,
    input  wire logic        device_configured,
    // default idle limit register
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    // result channel, one byte per transfer
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_kind,
    output logic [2:0]       result_interface,
    output logic [7:0]       result_byte,
    output logic             last_of_run
);

    // The controller sequences one item at a time: latch, decode, then a
    // compare walk over the addressed report, an emit walk, both in turn,
    // or an update. The datapath holds all stores and the output register,
    // so the item port reopens while the last byte still waits.
    jrf_pkg::cmd_t cmd;
    jrf_pkg::sts_t sts;

    jrf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    jrf_dpath u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .opcode            (opcode),
        .data_byte         (data_byte),
        .interface_index   (interface_index),
        .endpoint_ready    (endpoint_ready),
        .device_configured (device_configured),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .result_kind       (result_kind),
        .result_interface  (result_interface),
        .result_byte       (result_byte),
        .last_of_run       (last_of_run)
    );

endmodule

`default_nettype wire

FILE: design/jrf_checker.sv
`default_nettype none
`include "joystick_report_framer_and_idle_gate_macros.svh"

module jrf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] result_kind,
    input wire logic [2:0] result_interface,
    input wire logic [7:0] result_byte,
    input wire logic       last_of_run
);

    // stalled result holds
    `JRF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(result_byte) && $stable(result_kind)
        && $stable(result_interface) && $stable(last_of_run))

    // one item at a time: port closes right after a transfer
    `JRF_ASSERT_NEXT(a_in_closes, clk, rst_n, in_valid && in_ready, !in_ready)

    // idle period answers are single-byte runs
    `JRF_ASSERT_IMPL(a_idle_last, clk, rst_n,
        out_valid && result_kind == jrf_pkg::KIND_IDLE, last_of_run)

    // only defined result kinds, on existing interfaces
    `JRF_ASSERT_IMPL(a_kind_ok, clk, rst_n, out_valid,
        (result_kind <= jrf_pkg::KIND_IDLE)
        && (result_interface < 3'(jrf_pkg::NUM_INTERFACES)))

endmodule

bind joystick_report_framer_and_idle_gate jrf_checker u_jrf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_kind      (result_kind),
    .result_interface (result_interface),
    .result_byte      (result_byte),
    .last_of_run      (last_of_run)
);

`default_nettype wire
